@@ rtl/core/trs_model_matrix_builder_core_macros.svh @@
// Assertion macros shared by the checker of the model matrix builder.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef TRS_MODEL_MATRIX_BUILDER_CORE_MACROS_SVH
`define TRS_MODEL_MATRIX_BUILDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMMB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TMMB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/tmmb_pkg.sv @@
// Types, constants and fixed-point helpers of the model matrix builder.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
package tmmb_pkg;

    localparam int FIX_WIDTH        = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int WIDE_W           = 2 * FIX_WIDTH + 8;
    localparam int IN_W             = 240;
    localparam int OUT_W            = 384;
    localparam int NUM_STAGES       = 6;
    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

    typedef logic signed [FIX_WIDTH-1:0] fix_t;
    typedef logic signed [17:0]          trig_t;
    typedef logic signed [WIDE_W-1:0]    wide_t;
    typedef logic [16:0]                 sine_t;
    typedef sine_t sine_tab_t [SINE_TABLE_DEPTH+1];

    typedef enum logic [2:0] {
        REG_ANCHOR_X  = 3'd0,
        REG_ANCHOR_Y  = 3'd1,
        REG_ANCHOR_Z  = 3'd2,
        REG_CONTENT_X = 3'd3,
        REG_CONTENT_Y = 3'd4,
        REG_CONTENT_Z = 3'd5,
        REG_IGNORE    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } lookup_t;

    localparam wide_t HALF16  = wide_t'(32768);
    localparam wide_t FIX_MAX = (wide_t'(1) <<< (FIX_WIDTH - 1)) - wide_t'(1);
    localparam wide_t FIX_MIN = -FIX_MAX - wide_t'(1);

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (64'(i) * HALF_PI_Q31) / 64'(SINE_TABLE_DEPTH);
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 20; k++)
            begin
                if (term != 64'd0)
                begin
                    term = ((term * x) >> 31) / 64'(2 * k);
                    term = ((term * x) >> 31) / 64'(2 * k + 1);
                    if ((k % 2) == 1)
                        sum = sum - $signed(term);
                    else
                        sum = sum + $signed(term);
                end
            end
            if (sum < 0)
                sum = 64'sd0;
            v = (sum + 64'sd16384) >>> 15;
            if (v > 64'sd65536)
                v = 64'sd65536;
            tab[i] = v[16:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    function automatic lookup_t sine_addr(input logic [15:0] a);
        lookup_t              r;
        logic [14:0]          ph;
        logic [IDX_W+14:0]    prod;
        ph   = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        prod = (IDX_W + 15)'(ph) * (IDX_W + 15)'(SINE_TABLE_DEPTH);
        r.idx = prod[IDX_W+13:14];
        r.neg = a[15];
        return r;
    endfunction

    function automatic fix_t sat_fix(input wide_t v);
        wide_t c;
        c = (v > FIX_MAX) ? FIX_MAX : ((v < FIX_MIN) ? FIX_MIN : v);
        return c[FIX_WIDTH-1:0];
    endfunction

    function automatic wide_t round16(input wide_t v);
        return (v + HALF16) >>> 16;
    endfunction

    function automatic trig_t clamp_unit(input logic signed [55:0] v);
        logic signed [55:0] c;
        c = (v > 56'sd65536) ? 56'sd65536 : ((v < -56'sd65536) ? -56'sd65536 : v);
        return c[17:0];
    endfunction

    function automatic fix_t fix_in(input logic [31:0] v);
        return sat_fix(wide_t'($signed(v)));
    endfunction

    function automatic logic [31:0] fix_out(input fix_t v);
        return 32'(v);
    endfunction

endpackage

@@ rtl/core/trs_model_matrix_builder_core.sv @@
// Model matrix builder: Euler XYZ rotation, scale and anchor offset in Q16.16.
// Depends on tmmb_pkg for types, the sine table and fixed-point helpers.
//
// Usage:
// The s_ channel carries one node per transaction in s_tdata (position,
// angles, scale); the m_ channel returns the top three rows of the 4x4 model
// matrix in m_tdata. Anchor, content size and the anchor flag are written
// through cfg_wr_en, cfg_index and cfg_data. The user must write them only while no
// transaction is in flight; the block itself does not enforce this. One node
// is accepted per cycle unless the receiver stalls; the rate is set by the six-stage
// pipeline, whose stages each hold a valid bit and advance independently.
// When the receiver stalls, the output register holds its transaction and the
// stages behind it keep filling until they are all occupied; only then does
// s_tready fall. Nothing is dropped or repeated.
// Reset clears all valid bits and sets every configuration register to zero.
module trs_model_matrix_builder_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
    input  logic [tmmb_pkg::IN_W-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3, r2c0, r2c1, r2c2, r2c3
    output logic [tmmb_pkg::OUT_W-1:0] m_tdata
);

    localparam int NS = tmmb_pkg::NUM_STAGES;

    tmmb_pkg::fix_t anchor_reg [3];
    tmmb_pkg::fix_t content_reg [3];
    logic           ignore_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // Stage 1
    tmmb_pkg::lookup_t sl1_reg [3];
    tmmb_pkg::lookup_t cl1_reg [3];
    tmmb_pkg::fix_t    pos1_reg [3];
    tmmb_pkg::fix_t    scl1_reg [3];
    tmmb_pkg::wide_t   acp1_reg [3];
    // Stage 2
    tmmb_pkg::trig_t   s2_reg [3];
    tmmb_pkg::trig_t   c2_reg [3];
    tmmb_pkg::fix_t    pos2_reg [3];
    tmmb_pkg::fix_t    scl2_reg [3];
    tmmb_pkg::fix_t    ac2_reg [3];
    // Stage 3
    logic signed [35:0] c1c2_reg, c1s2_reg, s0c1_reg, c0c1_reg;
    logic signed [35:0] s0s1_reg, c0s1_reg, c0s2_reg, c0c2_reg, s0s2_reg, s0c2_reg;
    tmmb_pkg::trig_t   s3_reg [3];
    tmmb_pkg::trig_t   c3_reg [3];
    tmmb_pkg::fix_t    pos3_reg [3];
    tmmb_pkg::fix_t    scl3_reg [3];
    tmmb_pkg::wide_t   ascp3_reg [3];
    // Stage 4
    tmmb_pkg::trig_t   rot4_reg [3][3];
    tmmb_pkg::fix_t    asc4_reg [3];
    tmmb_pkg::fix_t    pos4_reg [3];
    tmmb_pkg::fix_t    scl4_reg [3];
    // Stage 5
    tmmb_pkg::wide_t   mrs5_reg [3][3];
    tmmb_pkg::wide_t   mat5_reg [3][3];
    tmmb_pkg::fix_t    pos5_reg [3];
    // Stage 6
    logic [31:0]       out6_reg [12];

    tmmb_pkg::lookup_t  sl_next [3];
    tmmb_pkg::lookup_t  cl_next [3];
    tmmb_pkg::trig_t    s_next [3];
    tmmb_pkg::trig_t    c_next [3];
    tmmb_pkg::fix_t     ac_next [3];
    tmmb_pkg::fix_t     pos2_next [3];
    tmmb_pkg::trig_t    rot_next [3][3];
    logic [31:0]        out_next [12];

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            ignore_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                anchor_reg[i]  <= '0;
                content_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                case (tmmb_pkg::cfg_index_t'(cfg_index))
                    tmmb_pkg::REG_ANCHOR_X:  anchor_reg[0]  <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_ANCHOR_Y:  anchor_reg[1]  <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_ANCHOR_Z:  anchor_reg[2]  <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_CONTENT_X: content_reg[0] <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_CONTENT_Y: content_reg[1] <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_CONTENT_Z: content_reg[2] <= tmmb_pkg::fix_in(cfg_data);
                    tmmb_pkg::REG_IGNORE:    ignore_reg     <= cfg_data[0];
                    default:                 ignore_reg     <= ignore_reg;
                endcase
            end
        end
    end

    // The rotation uses the negated angles; cosine is sine a quarter turn on.
    always_comb
    begin
        logic [15:0] na;
        for (int i = 0; i < 3; i++)
        begin
            na = 16'd0 - s_tdata[96 + 16 * i +: 16];
            sl_next[i] = tmmb_pkg::sine_addr(na);
            cl_next[i] = tmmb_pkg::sine_addr(na + 16'd16384);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sl1_reg[i]  <= sl_next[i];
                cl1_reg[i]  <= cl_next[i];
                pos1_reg[i] <= tmmb_pkg::fix_in(s_tdata[32 * i +: 32]);
                scl1_reg[i] <= tmmb_pkg::fix_in(s_tdata[144 + 32 * i +: 32]);
                acp1_reg[i] <= tmmb_pkg::wide_t'(anchor_reg[i])
                               * tmmb_pkg::wide_t'(content_reg[i]);
            end
        end
    end

    always_comb
    begin
        tmmb_pkg::trig_t sv;
        tmmb_pkg::trig_t cv;
        for (int i = 0; i < 3; i++)
        begin
            sv = $signed({1'b0, tmmb_pkg::SINE_TAB[sl1_reg[i].idx]});
            cv = $signed({1'b0, tmmb_pkg::SINE_TAB[cl1_reg[i].idx]});
            s_next[i] = sl1_reg[i].neg ? -sv : sv;
            c_next[i] = cl1_reg[i].neg ? -cv : cv;
            ac_next[i] = tmmb_pkg::sat_fix(tmmb_pkg::round16(acp1_reg[i]));
            pos2_next[i] = ignore_reg
                ? tmmb_pkg::sat_fix(tmmb_pkg::wide_t'(pos1_reg[i])
                                    + tmmb_pkg::wide_t'(ac_next[i]))
                : pos1_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_reg[i]   <= s_next[i];
                c2_reg[i]   <= c_next[i];
                pos2_reg[i] <= pos2_next[i];
                scl2_reg[i] <= scl1_reg[i];
                ac2_reg[i]  <= ac_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c1c2_reg <= c2_reg[1] * c2_reg[2];
            c1s2_reg <= c2_reg[1] * s2_reg[2];
            s0c1_reg <= s2_reg[0] * c2_reg[1];
            c0c1_reg <= c2_reg[0] * c2_reg[1];
            s0s1_reg <= s2_reg[0] * s2_reg[1];
            c0s1_reg <= c2_reg[0] * s2_reg[1];
            c0s2_reg <= c2_reg[0] * s2_reg[2];
            c0c2_reg <= c2_reg[0] * c2_reg[2];
            s0s2_reg <= s2_reg[0] * s2_reg[2];
            s0c2_reg <= s2_reg[0] * c2_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                s3_reg[i]    <= s2_reg[i];
                c3_reg[i]    <= c2_reg[i];
                pos3_reg[i]  <= pos2_reg[i];
                scl3_reg[i]  <= scl2_reg[i];
                ascp3_reg[i] <= tmmb_pkg::wide_t'(ac2_reg[i])
                                * tmmb_pkg::wide_t'(scl2_reg[i]);
            end
        end
    end

    // Two-factor entries round from Q32, three-factor entries from Q48.
    always_comb
    begin
        logic signed [55:0] t2 [4];
        logic signed [55:0] t3 [4];
        logic signed [55:0] h16;
        logic signed [55:0] h32;
        h16 = 56'sd32768;
        h32 = 56'sd2147483648;
        t2[0] = (56'(c1c2_reg) + h16) >>> 16;
        t2[1] = (-56'(c1s2_reg) + h16) >>> 16;
        t2[2] = (-56'(s0c1_reg) + h16) >>> 16;
        t2[3] = (56'(c0c1_reg) + h16) >>> 16;
        t3[0] = 56'(s0s1_reg) * 56'(c3_reg[2]) + (56'(c0s2_reg) <<< 16);
        t3[1] = -(56'(s0s1_reg) * 56'(s3_reg[2])) + (56'(c0c2_reg) <<< 16);
        t3[2] = -(56'(c0s1_reg) * 56'(c3_reg[2])) + (56'(s0s2_reg) <<< 16);
        t3[3] = 56'(c0s1_reg) * 56'(s3_reg[2]) + (56'(s0c2_reg) <<< 16);
        rot_next[0][0] = tmmb_pkg::clamp_unit(t2[0]);
        rot_next[0][1] = tmmb_pkg::clamp_unit(t2[1]);
        rot_next[0][2] = s3_reg[1];
        rot_next[1][0] = tmmb_pkg::clamp_unit((t3[0] + h32) >>> 32);
        rot_next[1][1] = tmmb_pkg::clamp_unit((t3[1] + h32) >>> 32);
        rot_next[1][2] = tmmb_pkg::clamp_unit(t2[2]);
        rot_next[2][0] = tmmb_pkg::clamp_unit((t3[2] + h32) >>> 32);
        rot_next[2][1] = tmmb_pkg::clamp_unit((t3[3] + h32) >>> 32);
        rot_next[2][2] = tmmb_pkg::clamp_unit(t2[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rot4_reg <= rot_next;
            for (int i = 0; i < 3; i++)
            begin
                asc4_reg[i] <= tmmb_pkg::sat_fix(tmmb_pkg::round16(ascp3_reg[i]));
                pos4_reg[i] <= pos3_reg[i];
                scl4_reg[i] <= scl3_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos5_reg[i] <= pos4_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    mrs5_reg[i][j] <= tmmb_pkg::wide_t'(rot4_reg[i][j])
                                      * tmmb_pkg::wide_t'(scl4_reg[j]);
                    mat5_reg[i][j] <= tmmb_pkg::wide_t'(asc4_reg[j])
                                      * tmmb_pkg::wide_t'(rot4_reg[i][j]);
                end
            end
        end
    end

    always_comb
    begin
        tmmb_pkg::wide_t t;
        for (int i = 0; i < 3; i++)
        begin
            t = tmmb_pkg::wide_t'(pos5_reg[i]);
            for (int j = 0; j < 3; j++)
            begin
                out_next[4 * i + j] = tmmb_pkg::fix_out(
                    tmmb_pkg::sat_fix(tmmb_pkg::round16(mrs5_reg[i][j])));
                t = t - tmmb_pkg::round16(mat5_reg[i][j]);
            end
            out_next[4 * i + 3] = tmmb_pkg::fix_out(tmmb_pkg::sat_fix(t));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            out6_reg <= out_next;
    end

    always_comb
    begin
        for (int k = 0; k < 12; k++)
            m_tdata[32 * k +: 32] = out6_reg[k];
    end

endmodule

@@ rtl/core/tmmb_chk.sv @@
// Port-level checker for the model matrix builder, bound to the top level.
// Depends on tmmb_pkg and the shared assertion macro header.
`include "trs_model_matrix_builder_core_macros.svh"

module tmmb_chk
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tmmb_pkg::OUT_W-1:0] m_tdata
);

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_next;
    end

    `TMMB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TMMB_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
    `TMMB_ASSERT_IMP(a_no_invented, m_tvalid, inflight_reg != 3'd0)
    `TMMB_ASSERT_IMP(a_depth_bound, 1'b1, inflight_reg <= 3'(tmmb_pkg::NUM_STAGES))

endmodule

bind trs_model_matrix_builder_core tmmb_chk u_tmmb_chk (.*);
